// ===== sv/mahd_pkg.sv =====
// Package for the MPEG audio header decoder: item and result types,
// bitrate and sample-rate tables, and the constants of the length divider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mahd_pkg;

  localparam logic [31:0] SYNC_MASK       = 32'hffe0_0000;
  localparam int          QUEUE_DEPTH_DEF = 2;

  // Frame length for a 44.1 kHz family rate is floor(160 * P / 147); the
  // reciprocal of 147 is scaled by 2^27 and pre-multiplied by 160.
  localparam int          DIV_SHIFT      = 27;
  localparam logic [27:0] DIV_RECIP_X160 = 28'd146087360;
  localparam logic [10:0] FRAME_BYTES_MAX = 11'd2047;

  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_RSVD   = 2'd2;
  localparam logic [1:0] VER_MPEG25 = 2'd3;

  localparam logic [1:0] FIDX_44K = 2'd0;
  localparam logic [1:0] FIDX_48K = 2'd1;
  localparam logic [1:0] FIDX_32K = 2'd2;
  localparam logic [1:0] FIDX_RSVD = 2'd3;

  localparam logic [1:0] MODE_SINGLE_CH = 2'd3;

  localparam logic [8:0] RATE_TAB [6][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Classified word handed from the front end to the length unit.
  typedef struct packed {
    logic        header_valid;
    logic [1:0]  version_code;
    logic [1:0]  layer_number;
    logic [15:0] sample_rate_hz;
    logic [8:0]  bitrate_kbps;
    logic [1:0]  chan_mode;
    logic [1:0]  channel_count;
    logic [10:0] frame_samples;
    logic        padding_flag;
    logic [2:0]  len_mult;
    logic [1:0]  freq_index;
  } mahd_item_t;

  typedef struct packed {
    logic        header_valid;
    logic [1:0]  version_code;
    logic [1:0]  layer_number;
    logic [15:0] sample_rate_hz;
    logic [8:0]  bitrate_kbps;
    logic [1:0]  chan_mode;
    logic [1:0]  channel_count;
    logic [10:0] frame_samples;
    logic [10:0] frame_bytes;
    logic        padding_flag;
  } mahd_result_t;

  function automatic logic [8:0] rate_kbps(input logic [2:0] row, input logic [3:0] idx);
    logic [8:0] val;
    val = 9'd0;
    if (row <= 3'd5) begin
      val = RATE_TAB[row][idx];
    end
    return val;
  endfunction

  function automatic logic [15:0] freq_hz(input logic [1:0] ver, input logic [1:0] fidx);
    logic [15:0] hz;
    hz = 16'd0;
    unique case ({ver, fidx})
      {VER_MPEG1, FIDX_44K}:  hz = 16'd44100;
      {VER_MPEG1, FIDX_48K}:  hz = 16'd48000;
      {VER_MPEG1, FIDX_32K}:  hz = 16'd32000;
      {VER_MPEG2, FIDX_44K}:  hz = 16'd22050;
      {VER_MPEG2, FIDX_48K}:  hz = 16'd24000;
      {VER_MPEG2, FIDX_32K}:  hz = 16'd16000;
      {VER_MPEG25, FIDX_44K}: hz = 16'd11025;
      {VER_MPEG25, FIDX_48K}: hz = 16'd12000;
      {VER_MPEG25, FIDX_32K}: hz = 16'd8000;
      default:                hz = 16'd0;
    endcase
    return hz;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mahd_ifs.sv =====
// Channel interfaces of the MPEG audio header decoder: header words in,
// decoded results out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mahd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  modport source (output valid, output header_word, input ready);
  modport sink (input valid, input header_word, output ready);
endinterface

interface mahd_out_if;
  logic        valid;
  logic        ready;
  logic        header_valid;
  logic [1:0]  version_code;
  logic [1:0]  layer_number;
  logic [15:0] sample_rate_hz;
  logic [8:0]  bitrate_kbps;
  logic [1:0]  chan_mode;
  logic [1:0]  channel_count;
  logic [10:0] frame_samples;
  logic [10:0] frame_bytes;
  logic        padding_flag;
  modport source (output valid, output header_valid, output version_code,
                  output layer_number, output sample_rate_hz, output bitrate_kbps,
                  output chan_mode, output channel_count, output frame_samples,
                  output frame_bytes, output padding_flag, input ready);
  modport sink (input valid, input header_valid, input version_code,
                input layer_number, input sample_rate_hz, input bitrate_kbps,
                input chan_mode, input channel_count, input frame_samples,
                input frame_bytes, input padding_flag, output ready);
endinterface

`default_nettype wire

// ===== sv/mpeg_audio_header_decoder.sv =====
// MPEG audio frame header decoder: one header word in, one decoded word out.
// Throughput is one word per cycle while the output is ready, the length unit
// being a two-stage multiply pipeline behind a short queue.
// Reset clears the valid flags and the queue count; payload is not reset.
// Depends on mahd_pkg, mahd_ifs, mahd_front, mahd_fifo and mahd_back.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_header_decoder
  import mahd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mahd_in_if.sink    in_if,
  mahd_out_if.source out_if
);

  logic         f_valid;
  logic         f_ready;
  mahd_item_t   f_item;
  logic         q_valid;
  logic         q_ready;
  mahd_item_t   q_item;
  mahd_result_t res;

  mahd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_word    (in_if.header_word),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  mahd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  mahd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_if.valid),
    .res_ready  (out_if.ready),
    .res        (res)
  );

  assign out_if.header_valid   = res.header_valid;
  assign out_if.version_code   = res.version_code;
  assign out_if.layer_number   = res.layer_number;
  assign out_if.sample_rate_hz = res.sample_rate_hz;
  assign out_if.bitrate_kbps   = res.bitrate_kbps;
  assign out_if.chan_mode      = res.chan_mode;
  assign out_if.channel_count  = res.channel_count;
  assign out_if.frame_samples  = res.frame_samples;
  assign out_if.frame_bytes    = res.frame_bytes;
  assign out_if.padding_flag   = res.padding_flag;

endmodule

`default_nettype wire

// ===== sv/mahd_front.sv =====
// Front end of the MPEG audio header decoder: checks and splits each header
// word into a registered item. Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_front
  import mahd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [31:0] in_word,
  output      logic        item_valid,
  input  wire logic        item_ready,
  output      mahd_item_t  item
);

  logic       valid_r;
  mahd_item_t item_r;
  mahd_item_t dec;
  logic [1:0] fidx;
  logic [1:0] lay;
  logic [1:0] ver;
  logic [2:0] row;
  logic [10:0] spf_base;

  always_comb begin
    fidx     = in_word[11:10];
    lay      = 2'(3'd4 - {1'b0, in_word[18:17]});
    ver      = 2'd3 - in_word[20:19];
    row      = 3'd2;
    spf_base = (lay > 2'd1) ? 11'd1152 : 11'd384;
    dec      = '0;
    if (lay == 2'd0) begin
      row = 3'd2;
    end else if (ver == VER_MPEG1) begin
      row = {1'b0, lay} - 3'd1;
    end else begin
      row = {1'b0, lay} + 3'd2;
    end
    if ((in_word & SYNC_MASK) == SYNC_MASK && fidx != FIDX_RSVD && ver != VER_RSVD) begin
      dec.header_valid   = 1'b1;
      dec.version_code   = ver;
      dec.layer_number   = lay;
      dec.sample_rate_hz = freq_hz(ver, fidx);
      dec.bitrate_kbps   = rate_kbps(row, in_word[15:12]);
      dec.chan_mode      = in_word[7:6];
      dec.channel_count  = (in_word[7:6] == MODE_SINGLE_CH) ? 2'd1 : 2'd2;
      dec.padding_flag   = in_word[9];
      dec.freq_index     = fidx;
      unique case (ver)
        VER_MPEG2: begin
          dec.frame_samples = spf_base >> 1;
          dec.len_mult      = (lay == 2'd1) ? 3'd1 : 3'd3;
        end
        VER_MPEG25: begin
          dec.frame_samples = spf_base >> 2;
          dec.len_mult      = (lay == 2'd1) ? 3'd2 : 3'd6;
        end
        default: begin
          dec.frame_samples = spf_base;
          dec.len_mult      = (lay == 2'd1) ? 3'd1 : 3'd3;
        end
      endcase
    end
  end

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= dec;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mahd_fifo.sv =====
// Short queue between the front end and the length unit of the MPEG audio
// header decoder. Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_fifo
  import mahd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  output      logic       push_ready,
  input  wire mahd_item_t push_item,
  output      logic       pop_valid,
  input  wire logic       pop_ready,
  output      mahd_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mahd_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mahd_back.sv =====
// Length unit of the MPEG audio header decoder: two-stage multiply and
// division for the frame length (by reciprocal for the 44.1 kHz family),
// ending in the output register. Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_back
  import mahd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         item_valid,
  output      logic         item_ready,
  input  wire mahd_item_t   item,
  output      logic         res_valid,
  input  wire logic         res_ready,
  output      mahd_result_t res
);

  logic         va_r;
  mahd_item_t   a_item_r;
  logic [11:0]  a_prod_r;
  logic         vb_r;
  mahd_result_t res_r;
  logic         rdy_a;
  logic         rdy_b;
  logic [39:0]  recip_prod;
  logic [12:0]  quot;
  logic [12:0]  with_pad;
  logic [10:0]  bytes;

  assign rdy_b      = !vb_r || res_ready;
  assign rdy_a      = !va_r || rdy_b;
  assign item_ready = rdy_a;
  assign res_valid  = vb_r;
  assign res        = res_r;

  always_comb begin
    recip_prod = 40'(a_prod_r) * 40'(DIV_RECIP_X160);
    quot       = 13'd0;
    case (a_item_r.freq_index)
      FIDX_44K: quot = 13'(recip_prod >> DIV_SHIFT);
      FIDX_48K: quot = {1'b0, a_prod_r};
      FIDX_32K: quot = 13'(({1'b0, a_prod_r, 1'b0} + {2'b00, a_prod_r}) >> 1);
      default:  quot = 13'd0;
    endcase
    with_pad = quot + {12'd0, a_item_r.padding_flag};
    if (a_item_r.bitrate_kbps == 9'd0) begin
      bytes = 11'd0;
    end else if (with_pad > {2'b00, FRAME_BYTES_MAX}) begin
      bytes = FRAME_BYTES_MAX;
    end else begin
      bytes = with_pad[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= item_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && rdy_a) begin
      a_item_r <= item;
      a_prod_r <= {9'd0, item.len_mult} * {3'd0, item.bitrate_kbps};
    end
    if (va_r && rdy_b) begin
      res_r.header_valid   <= a_item_r.header_valid;
      res_r.version_code   <= a_item_r.version_code;
      res_r.layer_number   <= a_item_r.layer_number;
      res_r.sample_rate_hz <= a_item_r.sample_rate_hz;
      res_r.bitrate_kbps   <= a_item_r.bitrate_kbps;
      res_r.chan_mode      <= a_item_r.chan_mode;
      res_r.channel_count  <= a_item_r.channel_count;
      res_r.frame_samples  <= a_item_r.frame_samples;
      res_r.frame_bytes    <= bytes;
      res_r.padding_flag   <= a_item_r.padding_flag;
    end
  end

`ifndef SYNTHESIS
  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && rdy_b) |=> vb_r)
    else $error("length stage lost a word");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !res_r.header_valid) |-> (res_r.frame_bytes == 11'd0
      && res_r.sample_rate_hz == 16'd0 && res_r.channel_count == 2'd0))
    else $error("rejected header carries non-zero fields");

  a_zero_rate_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && res_r.bitrate_kbps == 9'd0) |-> (res_r.frame_bytes == 11'd0))
    else $error("frame length non-zero at zero bitrate");
`endif

endmodule

`default_nettype wire
